[rtl/keystroke_rate_meter_with_hotkey_core_assert.svh]
// ----------------------------------------------------------------------------
// keystroke rate meter assertion macros
// shared property forms for the checker, sampled on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef KEYSTROKE_RATE_METER_WITH_HOTKEY_CORE_ASSERT_SVH
`define KEYSTROKE_RATE_METER_WITH_HOTKEY_CORE_ASSERT_SVH

// same-cycle implication
`define KRM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/krm_pkg.sv]
// ----------------------------------------------------------------------------
// krm_pkg
// shared types and constants of the keystroke rate meter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package krm_pkg;

    localparam int TIME_W = 32;
    localparam int W_W    = 12;
    localparam int SPAN_W = 22;
    localparam int WW_W   = 24;
    localparam int DEN_W  = 29;
    localparam int PPM_W  = 15;
    localparam int HOT_W  = 2;

    localparam logic [W_W-1:0]   W_RESET     = 12'd10;
    localparam logic [9:0]       SPAN_SCALE  = 10'd1000;
    localparam logic [4:0]       DEN_SCALE   = 5'd25;
    localparam logic [PPM_W-1:0] PPM_MAX     = 15'd32767;

    localparam logic        REQ_QUERY  = 1'b1;
    localparam logic        RES_HOTKEY = 1'b0;
    localparam logic        RES_RATE   = 1'b1;
    localparam logic [4:0]  KIND_KEY   = 5'd1;
    localparam logic [1:0]  ACT_RELEASE = 2'd0;
    localparam logic [1:0]  ACT_PRESS   = 2'd1;

    localparam logic [9:0] CODE_LCTRL = 10'd29;
    localparam logic [9:0] CODE_RCTRL = 10'd97;
    localparam logic [9:0] CODE_F9    = 10'd67;
    localparam logic [9:0] CODE_F10   = 10'd68;
    localparam logic [9:0] CODE_F11   = 10'd87;
    localparam logic [9:0] CODE_F12   = 10'd88;

    localparam logic [HOT_W-1:0] HOT_F9  = 2'd0;
    localparam logic [HOT_W-1:0] HOT_F10 = 2'd1;
    localparam logic [HOT_W-1:0] HOT_F11 = 2'd2;
    localparam logic [HOT_W-1:0] HOT_F12 = 2'd3;

    typedef struct packed {
        logic accept_event;
        logic load_query;
        logic setup;
        logic scale;
        logic issue;
        logic div_start;
        logic load_result;
    } krm_cmd_t;

    typedef struct packed {
        logic out_free;
        logic w_zero;
        logic can_issue;
        logic pipe_busy;
        logic div_done;
    } krm_sts_t;

endpackage

`default_nettype wire

[rtl/keystroke_rate_meter_with_hotkey_core.sv]
// ----------------------------------------------------------------------------
// keystroke_rate_meter_with_hotkey_core
// sliding-window key press rate meter with ctrl+F9..F12 hotkey detection
// ----------------------------------------------------------------------------
// A key event is taken without leaving the idle state; a ctrl+F9..F12 press
// gives a hotkey result straight into the output register. A rate query walks
// n ring entries (at most RING_DEPTH, one ring read per cycle through a
// four-stage walk pipeline) and then runs a bit-serial divide of width
// NUM_W = 24 + clog2(RING_DEPTH + 1). Only one query is in flight at a
// time, and no transaction is taken while a result waits on the output unless
// that result leaves in the same cycle. The ring is tracked by a fill count, so
// there is no clearing pass after reset. The window register sits at byte
// address 0 and should be written only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module keystroke_rate_meter_with_hotkey_core #(
    parameter int RING_DEPTH = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        req_type,
    input  wire logic [4:0]  event_kind,
    input  wire logic [9:0]  key_code,
    input  wire logic [1:0]  key_action,
    input  wire logic [31:0] now_ms,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             result_kind,
    output logic [1:0]       hotkey_index,
    output logic [14:0]      presses_per_minute
);

    import krm_pkg::*;

    localparam logic ADDR_WINDOW = 1'b0;

    logic [W_W-1:0] window_seconds_reg;
    logic           cfg_write;
    krm_cmd_t       cmd;
    krm_sts_t       sts;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == ADDR_WINDOW);
    assign prdata    = (paddr[2] == ADDR_WINDOW) ? {20'b0, window_seconds_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_seconds_reg <= W_RESET;
        end
        else if (cfg_write)
        begin
            window_seconds_reg <= pwdata[W_W-1:0];
        end
    end

    krm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    krm_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .window_seconds     (window_seconds_reg),
        .event_kind         (event_kind),
        .key_code           (key_code),
        .key_action         (key_action),
        .now_ms             (now_ms),
        .out_ready          (out_ready),
        .out_valid          (out_valid),
        .result_kind        (result_kind),
        .hotkey_index       (hotkey_index),
        .presses_per_minute (presses_per_minute)
    );

endmodule

`default_nettype wire

[rtl/krm_div.sv]
// ----------------------------------------------------------------------------
// krm_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module krm_div #(
    parameter int NUM_W = 33,
    parameter int DEN_W = 29
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] acc_reg;
    logic [NUM_W-1:0] numq_reg;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W:0]   rem_next;

    always_comb
    begin
        trial    = {acc_reg, numq_reg[NUM_W-1]};
        ge       = trial >= {1'b0, den};
        rem_next = ge ? (trial - {1'b0, den}) : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg  <= '0;
            numq_reg <= num;
        end
        else if (busy_reg)
        begin
            acc_reg  <= rem_next[DEN_W-1:0];
            numq_reg <= {numq_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = numq_reg;

endmodule

`default_nettype wire

[rtl/krm_ctrl.sv]
// ----------------------------------------------------------------------------
// krm_ctrl
// sequencer for key events and rate queries
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module krm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              req_type,
    output logic                   in_ready,
    input  wire krm_pkg::krm_sts_t sts,
    output krm_pkg::krm_cmd_t      cmd
);

    import krm_pkg::*;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SETUP     = 3'd1;
    localparam logic [2:0] ST_SCALE     = 3'd2;
    localparam logic [2:0] ST_WALK      = 3'd3;
    localparam logic [2:0] ST_DIV_START = 3'd4;
    localparam logic [2:0] ST_DIV_WAIT  = 3'd5;
    localparam logic [2:0] ST_FINISH    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE) && sts.out_free;
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (req_type == REQ_QUERY)
                    begin
                        cmd.load_query = 1'b1;
                        state_next     = ST_SETUP;
                    end
                    else
                    begin
                        cmd.accept_event = 1'b1;
                    end
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = sts.w_zero ? ST_FINISH : ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (sts.can_issue)
                begin
                    cmd.issue = 1'b1;
                end
                else if (!sts.pipe_busy)
                begin
                    state_next = ST_DIV_START;
                end
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[rtl/krm_datapath.sv]
// ----------------------------------------------------------------------------
// krm_datapath
// press ring, ctrl flag, weighted walk pipeline, divider and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module krm_datapath #(
    parameter int RING_DEPTH = 256
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire krm_pkg::krm_cmd_t            cmd,
    output krm_pkg::krm_sts_t                 sts,
    input  wire logic [krm_pkg::W_W-1:0]      window_seconds,
    input  wire logic [4:0]                   event_kind,
    input  wire logic [9:0]                   key_code,
    input  wire logic [1:0]                   key_action,
    input  wire logic [krm_pkg::TIME_W-1:0]   now_ms,
    input  wire logic                         out_ready,
    output logic                              out_valid,
    output logic                              result_kind,
    output logic [krm_pkg::HOT_W-1:0]         hotkey_index,
    output logic [krm_pkg::PPM_W-1:0]         presses_per_minute
);

    import krm_pkg::*;

    localparam int PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = SPAN_W + CNT_W;
    localparam int NUM_W  = SUM_W + 2;
    localparam int DIFF_W = TIME_W + 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(RING_DEPTH);

    logic [TIME_W-1:0] ring_mem [RING_DEPTH];

    logic [PTR_W-1:0]  wp_reg;
    logic [CNT_W-1:0]  fill_reg;
    logic              ctrl_held_reg;
    logic [TIME_W-1:0] now_q_reg;
    logic [SPAN_W-1:0] span_reg;
    logic [WW_W-1:0]   ww_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  issue_cnt_reg;
    logic [TIME_W-1:0] rd_data_reg;
    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    logic [TIME_W-1:0] age_reg;
    logic              empty_reg;
    logic [SPAN_W-1:0] diff_reg;
    logic              bad_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic              stop_reg;
    logic              out_valid_reg;
    logic              kind_reg;
    logic [HOT_W-1:0]  hot_reg;
    logic [PPM_W-1:0]  ppm_reg;

    logic              is_key;
    logic              is_ctrl;
    logic              press;
    logic              release_ctrl;
    logic              hot_valid;
    logic [HOT_W-1:0]  hot_idx;
    logic              hot_fire;
    logic              out_free;
    logic [DIFF_W-1:0] diff_full;
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  quot;
    logic              div_done;
    logic [PPM_W-1:0]  ppm_next;

    always_comb
    begin
        is_key       = event_kind == KIND_KEY;
        is_ctrl      = (key_code == CODE_LCTRL) || (key_code == CODE_RCTRL);
        press        = is_key && (key_action == ACT_PRESS);
        release_ctrl = is_key && (key_action == ACT_RELEASE) && is_ctrl;
        hot_valid    = 1'b1;
        hot_idx      = HOT_F9;
        case (key_code)
            CODE_F9:  hot_idx = HOT_F9;
            CODE_F10: hot_idx = HOT_F10;
            CODE_F11: hot_idx = HOT_F11;
            CODE_F12: hot_idx = HOT_F12;
            default:  hot_valid = 1'b0;
        endcase
        hot_fire = cmd.accept_event && press && !is_ctrl && ctrl_held_reg && hot_valid;
        out_free = !out_valid_reg || out_ready;
    end

    // ring storage, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.accept_event && press)
        begin
            ring_mem[wp_reg] <= now_ms;
        end
        if (cmd.issue)
        begin
            rd_data_reg <= ring_mem[rd_ptr_reg];
        end
    end

    // walk pipeline arithmetic
    assign diff_full = DIFF_W'(span_reg) - DIFF_W'(age_reg);
    assign num       = NUM_W'({sum_reg, 1'b0}) + NUM_W'(sum_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            now_q_reg <= now_ms;
        end
        if (cmd.setup)
        begin
            span_reg <= SPAN_W'(SPAN_W'(window_seconds) * SPAN_W'(SPAN_SCALE));
            ww_reg   <= WW_W'(window_seconds) * WW_W'(window_seconds);
        end
        if (cmd.scale)
        begin
            den_reg <= DEN_W'(ww_reg) * DEN_W'(DEN_SCALE);
        end
        age_reg   <= now_q_reg - rd_data_reg;
        empty_reg <= rd_data_reg == '0;
        diff_reg  <= diff_full[SPAN_W-1:0];
        bad_reg   <= empty_reg || diff_full[DIFF_W-1];
        if (cmd.scale)
        begin
            sum_reg <= '0;
        end
        else if (v3_reg && !stop_reg && !bad_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(diff_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            ctrl_held_reg <= 1'b0;
            rd_ptr_reg    <= '0;
            issue_cnt_reg <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            stop_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.accept_event && press)
            begin
                wp_reg <= (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
                if (fill_reg != FILL_MAX)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                if (is_ctrl)
                begin
                    ctrl_held_reg <= 1'b1;
                end
            end
            else if (cmd.accept_event && release_ctrl)
            begin
                ctrl_held_reg <= 1'b0;
            end
            if (cmd.scale)
            begin
                rd_ptr_reg    <= (wp_reg == '0) ? PTR_LAST : wp_reg - 1'b1;
                issue_cnt_reg <= fill_reg;
                stop_reg      <= 1'b0;
            end
            else if (cmd.issue)
            begin
                rd_ptr_reg    <= (rd_ptr_reg == '0) ? PTR_LAST : rd_ptr_reg - 1'b1;
                issue_cnt_reg <= issue_cnt_reg - 1'b1;
            end
            if (v3_reg && bad_reg)
            begin
                stop_reg <= 1'b1;
            end
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    krm_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num),
        .den   (den_reg),
        .done  (div_done),
        .quot  (quot)
    );

    // saturate, zero window answers zero
    always_comb
    begin
        if (sts.w_zero)
        begin
            ppm_next = '0;
        end
        else if (|quot[NUM_W-1:PPM_W])
        begin
            ppm_next = PPM_MAX;
        end
        else
        begin
            ppm_next = quot[PPM_W-1:0];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (hot_fire || cmd.load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hot_fire)
        begin
            kind_reg <= RES_HOTKEY;
            hot_reg  <= hot_idx;
            ppm_reg  <= '0;
        end
        else if (cmd.load_result)
        begin
            kind_reg <= RES_RATE;
            hot_reg  <= '0;
            ppm_reg  <= ppm_next;
        end
    end

    always_comb
    begin
        sts.out_free  = out_free;
        sts.w_zero    = window_seconds == '0;
        sts.can_issue = (issue_cnt_reg != '0) && !stop_reg;
        sts.pipe_busy = v1_reg || v2_reg || v3_reg;
        sts.div_done  = div_done;
    end

    assign out_valid          = out_valid_reg;
    assign result_kind        = kind_reg;
    assign hotkey_index       = hot_reg;
    assign presses_per_minute = ppm_reg;

endmodule

`default_nettype wire

[rtl/krm_checker.sv]
// ----------------------------------------------------------------------------
// krm_checker
// port-level checks of the keystroke rate meter, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "keystroke_rate_meter_with_hotkey_core_assert.svh"

module krm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        pready,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        req_type,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        result_kind,
    input wire logic [1:0]  hotkey_index,
    input wire logic [14:0] presses_per_minute
);

    import krm_pkg::*;

    `KRM_ASSERT_IMPL(a_pready_high, 1'b1, pready, "pready dropped")
    `KRM_ASSERT_IMPL(a_hotkey_no_rate, out_valid && (result_kind == RES_HOTKEY), presses_per_minute == '0, "hotkey result carries a rate")
    `KRM_ASSERT_IMPL(a_rate_no_hotkey, out_valid && (result_kind == RES_RATE), hotkey_index == '0, "rate answer carries a hotkey index")
    `KRM_ASSERT_NEXT(a_query_blocks_input, in_valid && in_ready && (req_type == REQ_QUERY), !in_ready, "input taken while a query is in flight")
    `KRM_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(result_kind) && $stable(presses_per_minute), "stalled result changed")

endmodule

bind keystroke_rate_meter_with_hotkey_core krm_checker u_krm_checker (.*);

`default_nettype wire

[tb/tb_keystroke_rate_meter_with_hotkey_core.sv]
// ----------------------------------------------------------------------------
// tb_keystroke_rate_meter_with_hotkey_core
// self-checking bench for the keystroke rate meter with ctrl+F9..F12 hotkeys
// ----------------------------------------------------------------------------
// A queue of key events and rate queries feeds a valid/ready driver. Every
// accepted transaction runs through a local model of the press ring, the ctrl
// flag and the window register, which queues the expected hotkey or rate
// result. A monitor compares each result field by field in order. The window
// is set over the APB port between phases, from zero through the maximum,
// with readback. Random idling on both sides, one long output stall that
// backs up the input, and a quiet final phase round it out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_keystroke_rate_meter_with_hotkey_core;

    import krm_pkg::*;

    localparam int RING_DEPTH     = 256;
    localparam int PTR_W          = $clog2(RING_DEPTH);
    localparam int CLK_PERIOD     = 10;
    localparam int HOLD_CYCLES    = 1500;
    localparam int SETTLE_CYCLES  = 20;
    localparam int DRAIN_CYCLES   = 400;
    localparam int TIMEOUT_CYCLES = 2_000_000;
    localparam int MAX_PRINTS     = 40;

    localparam logic [2:0] ADDR_WINDOW = 3'd0;
    localparam logic       REQ_EVENT   = 1'b0;
    localparam logic [1:0] ACT_REPEAT  = 2'd2;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam logic [4:0] KIND_SYN    = 5'd0;
    localparam logic [4:0] KIND_TOP    = 5'd31;

    typedef struct packed {
        logic        req;
        logic [4:0]  kind;
        logic [9:0]  code;
        logic [1:0]  action;
        logic [31:0] now;
    } key_request_t;

    typedef struct packed {
        logic             kind;
        logic [HOT_W-1:0] hot;
        logic [PPM_W-1:0] ppm;
    } meter_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        req_type = 1'b0;
    logic [4:0]  event_kind = '0;
    logic [9:0]  key_code   = '0;
    logic [1:0]  key_action = '0;
    logic [31:0] now_ms     = '0;
    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic        result_kind;
    logic [1:0]  hotkey_index;
    logic [14:0] presses_per_minute;

    // local copy of the block state
    logic [31:0]    press_ring [RING_DEPTH];
    logic [PTR_W-1:0] ring_wp   = '0;
    logic           ctrl_down  = 1'b0;
    logic [W_W-1:0] window_cfg = W_RESET;

    key_request_t  req_backlog[$];
    meter_result_t predicted_results[$];

    logic        in_taken      = 1'b0;
    logic        src_idle_on   = 1'b0;
    logic        sink_idle_on  = 1'b0;
    logic        hold_request  = 1'b0;
    int          src_gap       = 0;
    int          sink_gap      = 0;
    logic [31:0] clock_ms      = '0;

    int mismatches = 0;
    int n_accepted = 0;
    int n_queries  = 0;
    int n_hotkeys  = 0;
    int n_results  = 0;
    int n_windows  = 0;

    keystroke_rate_meter_with_hotkey_core #(
        .RING_DEPTH(RING_DEPTH)
    ) uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .req_type           (req_type),
        .event_kind         (event_kind),
        .key_code           (key_code),
        .key_action         (key_action),
        .now_ms             (now_ms),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .result_kind        (result_kind),
        .hotkey_index       (hotkey_index),
        .presses_per_minute (presses_per_minute)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("timeout with %0d results still expected", predicted_results.size());
        $display("== FAIL ==");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    // weighted presses per minute over the current window
    function automatic logic [PPM_W-1:0] weighted_rate(input logic [31:0] now);
        longint unsigned w;
        longint unsigned span;
        longint unsigned sum;
        longint unsigned age;
        longint unsigned ppm;
        logic [PTR_W-1:0] idx;
        logic [31:0]      stamp;
        logic [31:0]      diff;
        int               i;
        w = window_cfg;
        if (w == 0)
            return '0;
        span = w * SPAN_SCALE;
        sum  = 0;
        for (i = 0; i < RING_DEPTH; i++)
        begin
            idx   = PTR_W'(ring_wp - 1 - i);
            stamp = press_ring[idx];
            if (stamp == 0)
                break;
            diff = now - stamp;
            age  = diff;
            if (age > span)
                break;
            sum += span - age;
        end
        ppm = (3 * sum) / (DEN_SCALE * w * w);
        if (ppm > PPM_MAX)
            ppm = PPM_MAX;
        return ppm[PPM_W-1:0];
    endfunction

    function automatic void predict_meter(input key_request_t rq);
        meter_result_t res;
        logic          is_ctrl;
        logic          hot_hit;
        logic [HOT_W-1:0] hot;
        is_ctrl = (rq.code == CODE_LCTRL) || (rq.code == CODE_RCTRL);
        hot_hit = 1'b0;
        hot     = HOT_F9;
        if (rq.req == REQ_QUERY)
        begin
            res.kind = RES_RATE;
            res.hot  = '0;
            res.ppm  = weighted_rate(rq.now);
            predicted_results.push_back(res);
            n_queries++;
        end
        else if (rq.kind == KIND_KEY)
        begin
            if (rq.action == ACT_PRESS)
            begin
                press_ring[ring_wp] = rq.now;
                ring_wp = ring_wp + 1'b1;
                if (is_ctrl)
                    ctrl_down = 1'b1;
                else if (ctrl_down)
                begin
                    case (rq.code)
                        CODE_F9:  begin hot_hit = 1'b1; hot = HOT_F9;  end
                        CODE_F10: begin hot_hit = 1'b1; hot = HOT_F10; end
                        CODE_F11: begin hot_hit = 1'b1; hot = HOT_F11; end
                        CODE_F12: begin hot_hit = 1'b1; hot = HOT_F12; end
                        default: ;
                    endcase
                end
                if (hot_hit)
                begin
                    res.kind = RES_HOTKEY;
                    res.hot  = hot;
                    res.ppm  = '0;
                    predicted_results.push_back(res);
                    n_hotkeys++;
                end
            end
            else if (rq.action == ACT_RELEASE && is_ctrl)
                ctrl_down = 1'b0;
        end
    endfunction

    // input side: note acceptance and predict
    always @(posedge clk)
    begin
        in_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            n_accepted++;
            predict_meter('{req_type, event_kind, key_code, key_action, now_ms});
        end
    end

    always @(negedge clk)
    begin : request_driver
        key_request_t rq;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_taken)
            ;
        else if (src_gap > 0)
        begin
            src_gap--;
            in_valid <= 1'b0;
        end
        else if (req_backlog.size() > 0)
        begin
            rq = req_backlog.pop_front();
            req_type   <= rq.req;
            event_kind <= rq.kind;
            key_code   <= rq.code;
            key_action <= rq.action;
            now_ms     <= rq.now;
            in_valid   <= 1'b1;
            if (src_idle_on && $urandom_range(0, 7) == 0)
                src_gap = $urandom_range(1, 18);
        end
        else
            in_valid <= 1'b0;
    end

    always @(negedge clk)
    begin : result_acceptor
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_request)
        begin
            hold_request = 1'b0;
            sink_gap     = HOLD_CYCLES;
            out_ready   <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (sink_idle_on && $urandom_range(0, 7) == 0)
                sink_gap = $urandom_range(1, 18);
        end
    end

    always @(posedge clk)
    begin : result_checker
        meter_result_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (predicted_results.size() == 0)
                flag_mismatch("result transaction with nothing expected");
            else
            begin
                exp_res = predicted_results.pop_front();
                if (result_kind !== exp_res.kind)
                    flag_mismatch($sformatf("result_kind %0d, expected %0d",
                                            result_kind, exp_res.kind));
                if (hotkey_index !== exp_res.hot)
                    flag_mismatch($sformatf("hotkey_index %0d, expected %0d",
                                            hotkey_index, exp_res.hot));
                if (presses_per_minute !== exp_res.ppm)
                    flag_mismatch($sformatf("presses_per_minute %0d, expected %0d",
                                            presses_per_minute, exp_res.ppm));
            end
        end
    end

    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_WINDOW;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_window(input logic [W_W-1:0] w);
        logic [31:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd !== {{(32 - W_W){1'b0}}, w})
            flag_mismatch($sformatf("window readback %0d, expected %0d", rd, w));
    endtask

    task automatic set_window(input logic [W_W-1:0] w);
        logic [31:0] rd;
        apb_access(1'b1, {{(32 - W_W){1'b0}}, w}, rd);
        window_cfg = w;
        n_windows++;
        check_window(w);
    endtask

    task automatic push_req(input logic req, input logic [4:0] kind, input logic [9:0] code,
                            input logic [1:0] action, input logic [31:0] now);
        req_backlog.push_back('{req, kind, code, action, now});
    endtask

    // mostly well-formed key traffic and queries, some noise
    task automatic gen_traffic(input int n, input int unsigned step_max);
        key_request_t rq;
        int           r;
        int           k;
        for (k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            rq.req    = REQ_EVENT;
            rq.kind   = KIND_KEY;
            rq.code   = 10'($urandom);
            rq.action = ACT_PRESS;
            rq.now    = clock_ms;
            if (r < 30)
                rq.req = REQ_QUERY;
            else if (r < 85)
            begin
                case ($urandom_range(0, 9))
                    0: rq.code = CODE_LCTRL;
                    1: rq.code = CODE_RCTRL;
                    2: rq.code = CODE_F9;
                    3: rq.code = CODE_F10;
                    4: rq.code = CODE_F11;
                    5: rq.code = CODE_F12;
                    default: ;
                endcase
                r = $urandom_range(0, 9);
                if (r == 9)
                    rq.action = ACT_REPEAT;
                else if (r >= 6)
                    rq.action = ACT_RELEASE;
            end
            else
            begin
                rq.req    = ($urandom_range(0, 4) == 0) ? REQ_QUERY : REQ_EVENT;
                rq.kind   = 5'($urandom);
                rq.action = 2'($urandom);
                if ($urandom_range(0, 1))
                    rq.now = $urandom;
            end
            req_backlog.push_back(rq);
            clock_ms = clock_ms + $urandom_range(0, step_max);
        end
    endtask

    task automatic wait_idle();
        while (req_backlog.size() != 0 || in_valid || predicted_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [W_W-1:0] w, input int n, input int unsigned step_max,
                             input logic src_idle, input logic sink_idle);
        set_window(w);
        src_idle_on  = src_idle;
        sink_idle_on = sink_idle;
        gen_traffic(n, step_max);
        wait_idle();
    endtask

    initial
    begin : stimulus
        int k;
        for (k = 0; k < RING_DEPTH; k++)
            press_ring[k] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        check_window(W_RESET);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;

        // empty ring, press at time zero, ignored events
        push_req(REQ_QUERY, KIND_KEY, 10'd30, ACT_PRESS, 32'd5000);
        push_req(REQ_EVENT, KIND_KEY, 10'd30, ACT_PRESS, 32'd0);
        push_req(REQ_EVENT, KIND_KEY, 10'd30, ACT_PRESS, 32'd1000);
        push_req(REQ_EVENT, KIND_KEY, 10'd31, ACT_PRESS, 32'd2500);
        push_req(REQ_QUERY, KIND_KEY, 10'd0, ACT_RELEASE, 32'd4000);
        push_req(REQ_EVENT, KIND_SYN, 10'd30, ACT_PRESS, 32'd4100);
        push_req(REQ_EVENT, KIND_TOP, 10'd30, ACT_PRESS, 32'd4200);
        push_req(REQ_EVENT, KIND_KEY, 10'd30, ACT_REPEAT, 32'd4300);
        push_req(REQ_EVENT, KIND_KEY, 10'd30, ACT_UNUSED, 32'd4400);
        // hotkeys with left and right ctrl
        push_req(REQ_EVENT, KIND_KEY, CODE_LCTRL, ACT_PRESS, 32'd5000);
        push_req(REQ_EVENT, KIND_KEY, CODE_F9, ACT_PRESS, 32'd5100);
        push_req(REQ_EVENT, KIND_KEY, CODE_F10, ACT_PRESS, 32'd5200);
        push_req(REQ_EVENT, KIND_KEY, CODE_F11, ACT_PRESS, 32'd5300);
        push_req(REQ_EVENT, KIND_KEY, CODE_F12, ACT_PRESS, 32'd5400);
        push_req(REQ_EVENT, KIND_KEY, CODE_LCTRL, ACT_RELEASE, 32'd5500);
        push_req(REQ_EVENT, KIND_KEY, CODE_F9, ACT_PRESS, 32'd5600);
        push_req(REQ_EVENT, KIND_KEY, CODE_RCTRL, ACT_PRESS, 32'd5700);
        push_req(REQ_EVENT, KIND_SYN, CODE_RCTRL, ACT_RELEASE, 32'd5800);
        push_req(REQ_EVENT, KIND_KEY, CODE_F12, ACT_PRESS, 32'd5900);
        push_req(REQ_EVENT, KIND_KEY, CODE_RCTRL, ACT_RELEASE, 32'd6000);
        // stamp ahead of now, all-ones fields, age right at the window edge
        push_req(REQ_EVENT, KIND_KEY, 10'd1023, ACT_PRESS, 32'd50000);
        push_req(REQ_QUERY, KIND_KEY, 10'd0, ACT_PRESS, 32'd40000);
        push_req(REQ_QUERY, KIND_TOP, 10'd1023, ACT_UNUSED, 32'hFFFF_FFFF);
        push_req(REQ_QUERY, KIND_KEY, 10'd0, ACT_PRESS, 32'd60000);
        push_req(REQ_EVENT, KIND_KEY, 10'd0, ACT_PRESS, 32'hFFFF_FFFF);
        wait_idle();

        clock_ms = 32'd70000;
        run_phase(W_RESET, 150, 300, 1'b1, 1'b1);

        // one-second window with the ring full of fresh presses
        set_window(12'd1);
        for (k = 0; k < 260; k++)
        begin
            push_req(REQ_EVENT, KIND_KEY, 10'd30, ACT_PRESS, clock_ms);
            clock_ms = clock_ms + $urandom_range(0, 2);
        end
        gen_traffic(120, 1);
        wait_idle();

        run_phase(12'd4095, 120, 30000, 1'b1, 1'b1);
        run_phase(12'd0, 40, 500, 1'b1, 1'b1);
        clock_ms = 32'hFFFF_0000;
        run_phase(12'd3600, 120, 20000, 1'b1, 1'b1);

        // long output stall while queries keep coming
        set_window(12'd60);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        hold_request = 1'b1;
        for (k = 0; k < 16; k++)
        begin
            push_req(REQ_QUERY, KIND_KEY, 10'd0, ACT_PRESS, clock_ms);
            clock_ms = clock_ms + 200;
        end
        gen_traffic(24, 500);
        wait_idle();

        run_phase(12'd2, 150, 50, 1'b1, 1'b1);
        run_phase(12'($urandom_range(1, 4095)), 130, 2000, 1'b0, 1'b0);

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d transactions in (%0d queries), %0d results out (%0d hotkeys)",
                 n_accepted, n_queries, n_results, n_hotkeys);
        $display("%0d window settings incl. 0, 1 and 4095, full-ring walks, time wrap",
                 n_windows);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
